FILE: rtl/bpc_pkg.sv
// Shared types, constants and helpers for the barometric pressure compensation block.
`default_nettype none

package bpc_pkg;

	// Number of pressures averaged into the zero-altitude reference
	localparam int unsigned REF_SAMPLES_DEF = 16;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_AC1_AC2 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AC3_AC4 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AC5_AC6 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_B1_B2   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MC_MD   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_OSS     = 3'd5;

	// Datapath unit widths
	localparam int unsigned MUL_A_W   = 64;
	localparam int unsigned MUL_B_W   = 34;
	localparam int unsigned MUL_DIG_W = 16;
	localparam int unsigned DIV_W     = 32;

	// Compensation constants
	localparam logic signed [29:0] B6_OFFSET   = 30'sd4000;
	localparam logic [31:0]        B4_OFFSET   = 32'd32768;
	localparam logic [16:0]        B7_SCALE    = 17'd50000;
	localparam logic signed [33:0] P_SQ_COEF   = 34'sd3038;
	localparam logic signed [33:0] P_LIN_COEF  = -34'sd7357;
	localparam logic signed [63:0] P_OFFSET    = 64'sd3791;
	localparam logic signed [63:0] PA_MAX_WIDE = 64'sd262143;
	localparam logic [17:0]        PA_MAX      = 18'h3FFFF;

	typedef struct packed {
		logic [15:0] raw_temperature;
		logic [18:0] raw_pressure;
	} in_t;

	typedef struct packed {
		logic [17:0] pressure_pa;
		logic [17:0] zero_reference_pa;
		logic        reference_ready;
		logic        divide_fault;
	} out_t;

	// Compensation sequence, in execution order
	typedef enum logic [4:0] {
		S_X1T, S_DEN, S_X2, S_B6SQ, S_T1, S_T2, S_B3A, S_B3B, S_U1, S_U2, S_X3B,
		S_B4, S_B7, S_Q, S_Y1A, S_Y1B, S_Y2, S_Y3, S_FIN, S_ACC, S_REF
	} step_t;

	typedef enum logic [1:0] {
		UNIT_NONE,
		UNIT_MUL,
		UNIT_DIV
	} unit_t;

	typedef struct packed {
		logic  capture;
		logic  start;
		logic  wb;
		logic  fault;
		logic  push;
		step_t step;
	} dp_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic den_zero;
		logic b4_zero;
		logic out_busy;
	} dp_stat_t;

	// Which shared unit a step runs on; the reference average uses a reciprocal multiply
	function automatic unit_t step_unit(input step_t s);
		unit_t u;
		unique case (s) inside
			S_DEN, S_B3A, S_B3B, S_X3B, S_Y3, S_FIN, S_ACC: u = UNIT_NONE;
			S_X2, S_Q:                                       u = UNIT_DIV;
			default:                                         u = UNIT_MUL;
		endcase
		return u;
	endfunction

	// Signed divide by 2^k, truncating toward zero
	function automatic logic signed [63:0] sdiv_p2(input logic signed [63:0] x,
		input int unsigned k);
		logic signed [63:0] bias;
		bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
		return (x + bias) >>> k;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/bpc_mul.sv
// Multi-cycle signed multiplier: 16-bit digits of the wide operand per cycle.
`default_nettype none

module bpc_mul (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	input  wire logic [bpc_pkg::MUL_A_W-1:0]          a,
	input  wire logic signed [bpc_pkg::MUL_B_W-1:0]   b,
	output logic signed [bpc_pkg::MUL_A_W-1:0]        prod,
	output logic                                      done
);
	import bpc_pkg::*;

	localparam int unsigned DIGITS = MUL_A_W / MUL_DIG_W;
	localparam int unsigned CNT_W  = $clog2(DIGITS);
	localparam int unsigned PP_W   = MUL_DIG_W + 1 + MUL_B_W;

	logic [MUL_A_W-1:0]        a_q;
	logic signed [MUL_B_W-1:0] b_q;
	logic signed [MUL_A_W-1:0] acc_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic signed [PP_W-1:0]    pp;

	// Top digit first, so the running sum shifts by a fixed amount
	always_comb begin
		pp = $signed({1'b0, a_q[MUL_A_W-1 -: MUL_DIG_W]}) * b_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(DIGITS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			a_q   <= a_q << MUL_DIG_W;
			acc_q <= (acc_q <<< MUL_DIG_W) + MUL_A_W'(pp);
		end
	end

	assign prod = acc_q;
	assign done = done_q;

endmodule

`default_nettype wire

FILE: rtl/bpc_div.sv
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module bpc_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [bpc_pkg::DIV_W-1:0]  num,
	input  wire logic [bpc_pkg::DIV_W-1:0]  den,
	output logic [bpc_pkg::DIV_W-1:0]       quo,
	output logic                            done
);
	import bpc_pkg::*;

	localparam int unsigned CNT_W = $clog2(DIV_W);

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_W:0]   shifted;
	logic [DIV_W:0]   diff;
	logic             ge;

	// Trial subtract of the divisor from the shifted remainder
	always_comb begin
		shifted = {rem_q, quo_q[DIV_W-1]};
		diff    = shifted - {1'b0, den_q};
		ge      = !diff[DIV_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(DIV_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

`default_nettype wire

FILE: rtl/bpc_ctrl.sv
// Sequencer that walks the compensation steps and drives the datapath.
`default_nettype none

module bpc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire bpc_pkg::dp_stat_t stat,
	output bpc_pkg::dp_cmd_t       cmd
);
	import bpc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ISSUE = 4'b0010,
		ST_WAIT  = 4'b0100,
		ST_PUSH  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	step_t  step_q, step_d;
	step_t  step_nx;
	unit_t  unit;
	logic   unit_done;
	logic   fault_hit;

	always_comb begin
		unit      = step_unit(step_q);
		step_nx   = step_t'(step_q + 5'd1);
		unit_done = (unit == UNIT_MUL && stat.mul_done) ||
			(unit == UNIT_DIV && stat.div_done);
		// A zero divisor ends the math early; the reference bookkeeping still runs
		fault_hit = (step_q == S_X2 && stat.den_zero) ||
			(step_q == S_Q && stat.b4_zero);

		state_d  = state_q;
		step_d   = step_q;
		cmd      = '0;
		cmd.step = step_q;

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					step_d      = S_X1T;
					state_d     = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				if (fault_hit) begin
					cmd.fault = 1'b1;
					step_d    = S_ACC;
				end else if (unit == UNIT_NONE) begin
					cmd.wb = 1'b1;
					step_d = step_nx;
				end else begin
					cmd.start = 1'b1;
					state_d   = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (unit_done) begin
					cmd.wb = 1'b1;
					if (step_q == S_REF) begin
						state_d = ST_PUSH;
					end else begin
						step_d  = step_nx;
						state_d = ST_ISSUE;
					end
				end
			end
			ST_PUSH: begin
				if (!stat.out_busy) begin
					cmd.push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= S_X1T;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

endmodule

`default_nettype wire

FILE: rtl/bpc_dpath.sv
// Datapath: calibration registers, working registers, shared multiplier and divider.
`default_nettype none

module bpc_dpath #(
	parameter int unsigned REF_SAMPLES = bpc_pkg::REF_SAMPLES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire bpc_pkg::dp_cmd_t                  cmd,
	output bpc_pkg::dp_stat_t                      stat,
	input  wire bpc_pkg::in_t                      in_data,
	input  wire logic                              cfg_valid,
	input  wire logic [bpc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [31:0]                       cfg_data,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output bpc_pkg::out_t                          out_data
);
	import bpc_pkg::*;

	localparam int unsigned CNT_W = $clog2(REF_SAMPLES + 1);
	localparam int unsigned SUM_W = 18 + $clog2(REF_SAMPLES);
	localparam logic [CNT_W-1:0] REF_CNT = CNT_W'(REF_SAMPLES);
	// Exact floor(sum / REF_SAMPLES) as (sum * REF_RECIP) >> REF_SH for any sum below 2^SUM_W
	localparam int unsigned REF_SH = SUM_W + $clog2(REF_SAMPLES);
	localparam logic signed [MUL_B_W-1:0] REF_RECIP = MUL_B_W'(
		((64'd1 << REF_SH) + 64'(REF_SAMPLES) - 64'd1) / 64'(REF_SAMPLES));

	// Calibration and setting registers
	logic [31:0] cal_ac1_ac2_q, cal_ac3_ac4_q, cal_ac5_ac6_q, cal_b1_b2_q, cal_mc_md_q;
	logic [1:0]  oss_q;

	// Working registers
	logic [15:0]        ut_q;
	logic [18:0]        up_q;
	logic signed [17:0] x1t_q;
	logic signed [18:0] den_q;
	logic               neg_q;
	logic signed [29:0] b6_q;
	logic [47:0]        b6sq_q;
	logic signed [63:0] acc_q;
	logic [31:0]        b3_q;
	logic [16:0]        b4_q;
	logic [31:0]        b7_q;
	logic [31:0]        p_q;
	logic [17:0]        pa_q;
	logic               fault_q;

	// Reference state
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic [17:0]      ref_q;
	logic             out_valid_q;
	out_t             out_q;

	// Unit ports
	logic                      mul_start, div_start;
	logic [MUL_A_W-1:0]        mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_A_W-1:0] mul_p;
	logic                      mul_done;
	logic [DIV_W-1:0]          div_num, div_den, div_q;
	logic                      div_done;

	// Calibration fields
	logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
	logic [15:0]        ac4, ac5, ac6;

	// Operand helpers
	logic signed [16:0] t_diff;
	logic signed [26:0] mc_sh;
	logic [26:0]        mc_mag;
	logic [18:0]        den_mag;
	logic [31:0]        x3_low;
	logic [31:0]        b7_a;
	logic [23:0]        p_hi;
	logic signed [29:0] x2_v;
	logic signed [63:0] fin_sum;
	logic               ref_full;

	always_comb begin
		ac1 = $signed(cal_ac1_ac2_q[31:16]);
		ac2 = $signed(cal_ac1_ac2_q[15:0]);
		ac3 = $signed(cal_ac3_ac4_q[31:16]);
		ac4 = cal_ac3_ac4_q[15:0];
		ac5 = cal_ac5_ac6_q[31:16];
		ac6 = cal_ac5_ac6_q[15:0];
		b1  = $signed(cal_b1_b2_q[31:16]);
		b2  = $signed(cal_b1_b2_q[15:0]);
		mc  = $signed(cal_mc_md_q[31:16]);
		md  = $signed(cal_mc_md_q[15:0]);
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_ac1_ac2_q <= '0;
			cal_ac3_ac4_q <= '0;
			cal_ac5_ac6_q <= '0;
			cal_b1_b2_q   <= '0;
			cal_mc_md_q   <= '0;
			oss_q         <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_AC1_AC2: cal_ac1_ac2_q <= cfg_data;
				CFG_AC3_AC4: cal_ac3_ac4_q <= cfg_data;
				CFG_AC5_AC6: cal_ac5_ac6_q <= cfg_data;
				CFG_B1_B2:   cal_b1_b2_q   <= cfg_data;
				CFG_MC_MD:   cal_mc_md_q   <= cfg_data;
				CFG_OSS:     oss_q         <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Operand selection for the shared units
	always_comb begin
		t_diff  = $signed({1'b0, ut_q}) - $signed({1'b0, ac6});
		mc_sh   = {mc, 11'b0};
		mc_mag  = mc_sh[26] ? 27'(-mc_sh) : 27'(mc_sh);
		den_mag = den_q[18] ? 19'(-den_q) : 19'(den_q);
		x3_low  = acc_q[31:0] + B4_OFFSET;
		b7_a    = 32'(up_q) - b3_q;
		p_hi    = p_q[31:8];

		mul_a   = '0;
		mul_b   = '0;
		div_num = '0;
		div_den = '0;
		case (cmd.step)
			S_X1T: begin
				mul_a = MUL_A_W'(t_diff);
				mul_b = MUL_B_W'($signed({1'b0, ac5}));
			end
			S_B6SQ: begin
				mul_a = MUL_A_W'(b6_q);
				mul_b = MUL_B_W'(b6_q);
			end
			S_T1: begin
				mul_a = MUL_A_W'(b6sq_q);
				mul_b = MUL_B_W'(b2);
			end
			S_T2: begin
				mul_a = MUL_A_W'(b6_q);
				mul_b = MUL_B_W'(ac2);
			end
			S_U1: begin
				mul_a = MUL_A_W'(b6_q);
				mul_b = MUL_B_W'(ac3);
			end
			S_U2: begin
				mul_a = MUL_A_W'(b6sq_q);
				mul_b = MUL_B_W'(b1);
			end
			S_B4: begin
				mul_a = MUL_A_W'(x3_low);
				mul_b = MUL_B_W'($signed({1'b0, ac4}));
			end
			S_B7: begin
				mul_a = MUL_A_W'(b7_a);
				mul_b = MUL_B_W'($signed({1'b0, B7_SCALE >> oss_q}));
			end
			S_Y1A: begin
				mul_a = MUL_A_W'(p_hi);
				mul_b = MUL_B_W'($signed({1'b0, p_hi}));
			end
			S_Y1B: begin
				mul_a = acc_q;
				mul_b = P_SQ_COEF;
			end
			S_Y2: begin
				mul_a = MUL_A_W'(p_q);
				mul_b = P_LIN_COEF;
			end
			S_X2: begin
				div_num = DIV_W'(mc_mag);
				div_den = DIV_W'(den_mag);
			end
			S_Q: begin
				div_num = b7_q[31] ? b7_q : {b7_q[30:0], 1'b0};
				div_den = DIV_W'(b4_q);
			end
			S_REF: begin
				mul_a = MUL_A_W'(sum_q);
				mul_b = REF_RECIP;
			end
			default: ;
		endcase
	end

	assign mul_start = cmd.start && (step_unit(cmd.step) == UNIT_MUL);
	assign div_start = cmd.start && (step_unit(cmd.step) == UNIT_DIV);

	bpc_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.prod  (mul_p),
		.done  (mul_done)
	);

	bpc_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.quo   (div_q),
		.done  (div_done)
	);

	// Writeback helpers
	always_comb begin
		x2_v    = neg_q ? -$signed(30'(div_q)) : $signed(30'(div_q));
		fin_sum = $signed(64'(p_q)) + acc_q;
	end

	// Working register writeback
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ut_q    <= in_data.raw_temperature;
			up_q    <= in_data.raw_pressure;
			fault_q <= 1'b0;
		end
		if (div_start && cmd.step == S_X2) begin
			neg_q <= mc[15] ^ den_q[18];
		end
		if (cmd.fault) begin
			fault_q <= 1'b1;
			pa_q    <= '0;
		end
		if (cmd.wb) begin
			case (cmd.step)
				S_X1T:  x1t_q  <= 18'(sdiv_p2(mul_p, 15));
				S_DEN:  den_q  <= 19'(x1t_q) + 19'(md);
				S_X2:   b6_q   <= 30'(x1t_q) + x2_v - B6_OFFSET;
				S_B6SQ: b6sq_q <= mul_p[59:12];
				S_T1:   acc_q  <= sdiv_p2(mul_p, 11);
				S_T2:   acc_q  <= acc_q + sdiv_p2(mul_p, 11);
				S_B3A:  acc_q  <= (acc_q + (64'(ac1) <<< 2)) <<< oss_q;
				S_B3B:  b3_q   <= 32'(sdiv_p2(acc_q + 64'sd2, 2));
				S_U1:   acc_q  <= sdiv_p2(mul_p, 13);
				S_U2:   acc_q  <= acc_q + sdiv_p2(mul_p, 16);
				S_X3B:  acc_q  <= sdiv_p2(acc_q + 64'sd2, 2);
				S_B4:   b4_q   <= mul_p[31:15];
				S_B7:   b7_q   <= mul_p[31:0];
				S_Q:    p_q    <= b7_q[31] ? {div_q[30:0], 1'b0} : div_q;
				S_Y1A:  acc_q  <= mul_p;
				S_Y1B:  acc_q  <= sdiv_p2(mul_p, 16);
				S_Y2:   acc_q  <= acc_q + sdiv_p2(mul_p, 16);
				S_Y3:   acc_q  <= sdiv_p2(acc_q + P_OFFSET, 4);
				S_FIN: begin
					if (fin_sum < 64'sd0) begin
						pa_q <= '0;
					end else if (fin_sum > PA_MAX_WIDE) begin
						pa_q <= PA_MAX;
					end else begin
						pa_q <= fin_sum[17:0];
					end
				end
				default: ;
			endcase
		end
	end

	assign ref_full = (cnt_q == REF_CNT);

	// Reference average and output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			cnt_q       <= '0;
			ref_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.wb && cmd.step == S_ACC && !fault_q && cnt_q < REF_CNT) begin
				sum_q <= sum_q + SUM_W'(pa_q);
				cnt_q <= cnt_q + 1'b1;
			end
			// Sum is frozen once full, so redoing the quotient is harmless
			if (cmd.wb && cmd.step == S_REF && ref_full) begin
				ref_q <= mul_p[REF_SH +: 18];
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_q.pressure_pa       <= pa_q;
			out_q.zero_reference_pa <= ref_full ? ref_q : '0;
			out_q.reference_ready   <= ref_full;
			out_q.divide_fault      <= fault_q;
		end
	end

	always_comb begin
		stat.mul_done = mul_done;
		stat.div_done = div_done;
		stat.den_zero = (den_q == '0);
		stat.b4_zero  = (b4_q == '0);
		stat.out_busy = out_valid_q && !out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

FILE: rtl/barometric_pressure_compensation.sv
// Top level of the barometric pressure compensation block.
//
//  Channel  Signals                                   Direction  Beat
//  in       in_valid / in_ready / in_data             sink       raw temperature and pressure
//  out      out_valid / out_ready / out_data          source     compensated pressure, reference
//  cfg      cfg_valid / cfg_ready / cfg_index, data   sink       one calibration register write
//
// One input beat is worked on at a time. Two divides (32 quotient bits plus issue and
// writeback) and twelve multiplies (four 16-bit digits plus issue and writeback) set
// the time per item; seven steps that use neither unit, the accept and the push add the rest.
// A divide fault skips the math. The finished beat sits in an output register, so a new
// input is taken while it waits; a push waits only on a stalled beat. cfg_ready is
// always high. Async reset.
`default_nettype none

module barometric_pressure_compensation #(
	parameter int unsigned REF_SAMPLES = bpc_pkg::REF_SAMPLES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire bpc_pkg::in_t                   in_data,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output bpc_pkg::out_t                       out_data,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [31:0]                    cfg_data
);
	import bpc_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	bpc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	bpc_dpath #(
		.REF_SAMPLES(REF_SAMPLES)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_data  (in_data),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

`default_nettype wire

FILE: rtl/bpc_checker.sv
// Port-level checker for the compensation block, bound to the top level.
`default_nettype none

module bpc_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          in_valid,
	input wire logic          in_ready,
	input wire logic          out_valid,
	input wire logic          out_ready,
	input wire bpc_pkg::out_t out_data
);
	import bpc_pkg::*;

	// A stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	// Reference reads zero until it is formed
	a_ref_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.reference_ready |-> out_data.zero_reference_pa == '0)
		else $error("reference nonzero before ready");

	// A divide fault forces zero pressure
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.divide_fault |-> out_data.pressure_pa == '0)
		else $error("faulted beat carries pressure");

	// One item in flight: no input right after an accepted one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in flight");

endmodule

bind barometric_pressure_compensation bpc_checker u_bpc_checker (.*);

`default_nettype wire

FILE: tb/barometric_pressure_compensation_test.sv
// Testbench for the barometric pressure compensation block: directed and random samples.
`default_nettype none

module barometric_pressure_compensation_test;
	import bpc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned SETTLE_CYCLES = 400;
	localparam int unsigned REF_COUNT = REF_SAMPLES_DEF;
	// An index past the register list; the block must ignore it
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd6;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	// Predictor copy of calibration and reference state
	bit [31:0] cal_ac12, cal_ac34, cal_ac56, cal_b12, cal_mcmd;
	bit [1:0] cal_oss;
	bit [25:0] ref_sum;
	int unsigned ref_taken;
	bit [17:0] ref_value;

	out_t pending_results[$];
	int unsigned errors;
	int unsigned cycles;
	int unsigned idle_pct;
	int unsigned stall_pct;

	barometric_pressure_compensation dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Clock, period 2
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic longint sext16(input bit [15:0] v);
		return longint'(signed'(v));
	endfunction

	// Integer compensation; returns 0 on a zero divisor
	function automatic bit compensate(input bit [15:0] ut, input bit [18:0] up,
		output bit [17:0] pa);
		longint ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md;
		longint x1, x2, x3, b3, b5, b6, b6sq, p;
		bit [31:0] ac4, x3w, b3w, b4, b7, q;
		ac1 = sext16(cal_ac12[31:16]);
		ac2 = sext16(cal_ac12[15:0]);
		ac3 = sext16(cal_ac34[31:16]);
		ac4 = {16'd0, cal_ac34[15:0]};
		ac5 = longint'(cal_ac56[31:16]);
		ac6 = longint'(cal_ac56[15:0]);
		b1 = sext16(cal_b12[31:16]);
		b2 = sext16(cal_b12[15:0]);
		mc = sext16(cal_mcmd[31:16]);
		md = sext16(cal_mcmd[15:0]);
		pa = '0;
		x1 = (longint'(ut) - ac6) * ac5 / 32768;
		if (x1 + md == 0)
			return 1'b0;
		x2 = mc * 2048 / (x1 + md);
		b5 = x1 + x2;
		b6 = b5 - 4000;
		b6sq = b6 * b6 / 4096;
		x1 = b2 * b6sq / 2048;
		x2 = ac2 * b6 / 2048;
		x3 = x1 + x2;
		b3 = ((ac1 * 4 + x3) * (longint'(1) << cal_oss) + 2) / 4;
		x1 = ac3 * b6 / 8192;
		x2 = b1 * b6sq / 65536;
		x3 = (x1 + x2 + 2) / 4;
		x3w = 32'(x3 + 32768);
		b4 = (ac4 * x3w) / 32'd32768;
		if (b4 == 0)
			return 1'b0;
		b3w = 32'(b3);
		b7 = ({13'd0, up} - b3w) * (32'd50000 >> cal_oss);
		if (b7 < 32'h8000_0000)
			q = (b7 * 32'd2) / b4;
		else
			q = (b7 / b4) * 32'd2;
		p = longint'(q);
		x1 = (p / 256) * (p / 256);
		x1 = x1 * 3038 / 65536;
		x2 = (-7357 * p) / 65536;
		p = p + (x1 + x2 + 3791) / 16;
		if (p < 0)
			p = 0;
		if (p > 262143)
			p = 262143;
		pa = 18'(p);
		return 1'b1;
	endfunction

	// Expected beat for one accepted sample, with reference update
	function automatic out_t predict_sample(input in_t s);
		out_t r;
		bit ok;
		bit [17:0] pa;
		ok = compensate(s.raw_temperature, s.raw_pressure, pa);
		if (ok && ref_taken < REF_COUNT) begin
			ref_sum = ref_sum + 26'(pa);
			ref_taken++;
			if (ref_taken == REF_COUNT)
				ref_value = 18'(ref_sum / REF_COUNT);
		end
		r.pressure_pa = ok ? pa : '0;
		r.reference_ready = ref_taken >= REF_COUNT;
		r.zero_reference_pa = r.reference_ready ? ref_value : '0;
		r.divide_fault = !ok;
		return r;
	endfunction

	// Receiver back-pressure
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Result checker
	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat %h", $time, out_data);
			end else begin
				want = pending_results.pop_front();
				if (out_data.pressure_pa !== want.pressure_pa) begin
					errors++;
					$display("%0t: pressure_pa exp %0d got %0d", $time,
						want.pressure_pa, out_data.pressure_pa);
				end
				if (out_data.zero_reference_pa !== want.zero_reference_pa) begin
					errors++;
					$display("%0t: zero_reference_pa exp %0d got %0d", $time,
						want.zero_reference_pa, out_data.zero_reference_pa);
				end
				if (out_data.reference_ready !== want.reference_ready) begin
					errors++;
					$display("%0t: reference_ready exp %0b got %0b", $time,
						want.reference_ready, out_data.reference_ready);
				end
				if (out_data.divide_fault !== want.divide_fault) begin
					errors++;
					$display("%0t: divide_fault exp %0b got %0b", $time,
						want.divide_fault, out_data.divide_fault);
				end
			end
		end
	end

	// Send one sample beat; valid stays up for back-to-back beats
	task automatic send_sample(input bit [15:0] ut, input bit [18:0] up);
		in_t s;
		s.raw_temperature = ut;
		s.raw_pressure = up;
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= s;
		do
			@(posedge clk);
		while (!in_ready);
		pending_results.push_back(predict_sample(s));
	endtask

	// Drop valid and wait until every expected beat has come back
	task automatic drain;
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input bit [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_AC1_AC2: cal_ac12 = val;
			CFG_AC3_AC4: cal_ac34 = val;
			CFG_AC5_AC6: cal_ac56 = val;
			CFG_B1_B2: cal_b12 = val;
			CFG_MC_MD: cal_mcmd = val;
			CFG_OSS: cal_oss = val[1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_calibration(input bit [31:0] w0, input bit [31:0] w1,
		input bit [31:0] w2, input bit [31:0] w3, input bit [31:0] w4, input bit [1:0] oss);
		write_reg(CFG_AC1_AC2, w0);
		write_reg(CFG_AC3_AC4, w1);
		write_reg(CFG_AC5_AC6, w2);
		write_reg(CFG_B1_B2, w3);
		write_reg(CFG_MC_MD, w4);
		write_reg(CFG_OSS, {30'd0, oss});
	endtask

	function automatic bit [31:0] pair(input int hi, input int lo);
		bit [15:0] h, l;
		h = 16'(hi);
		l = 16'(lo);
		return {h, l};
	endfunction

	function automatic bit [15:0] jitter(input int v, input int span);
		return 16'(v + int'($urandom_range(2 * span)) - span);
	endfunction

	// Typical sensor calibration with some spread
	task automatic load_typical(input bit [1:0] oss);
		load_calibration(pair(jitter(408, 300), jitter(-72, 100)),
			pair(jitter(-14383, 2000), jitter(32741, 2000)),
			pair(jitter(32757, 2000), jitter(23153, 2000)),
			pair(jitter(6190, 1000), jitter(4, 20)),
			pair(jitter(-8711, 1000), jitter(2868, 500)), oss);
	endtask

	// Reset calibration: zero temperature divisor on every sample
	task automatic test_reset_state;
		send_sample(16'd0, 19'd0);
		send_sample(16'hFFFF, 19'h7FFFF);
		send_sample(16'h5555, 19'h2AAAA);
		drain();
	endtask

	// Datasheet calibration, field extremes and all oversampling settings
	task automatic test_datasheet;
		for (int o = 0; o < 4; o++) begin
			load_calibration(pair(408, -72), pair(-14383, 32741), pair(32757, 23153),
				pair(6190, 4), pair(-8711, 2868), o[1:0]);
			send_sample(16'd27898, 19'd23843 << o);
			send_sample(16'd0, 19'd0);
			send_sample(16'hFFFF, 19'h7FFFF);
			send_sample(16'd27898, 19'h7FFFF);
			drain();
		end
	endtask

	// Zero divisors, an ignored index and saturating calibration
	task automatic test_faults_and_extremes;
		load_calibration(pair(408, -72), pair(-14383, 0), pair(32757, 23153),
			pair(6190, 4), pair(-8711, 1), 2'd0);
		send_sample(16'd27898, 19'd23843);
		drain();
		write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
		send_sample(16'd30000, 19'd40000);
		drain();
		load_calibration(pair(408, -72), pair(-14383, 32741), pair(0, 23153),
			pair(6190, 4), pair(-8711, 0), 2'd1);
		send_sample(16'd27898, 19'd23843);
		drain();
		load_calibration(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 2'd3);
		send_sample(16'hFFFF, 19'h7FFFF);
		send_sample(16'd0, 19'd0);
		drain();
		load_calibration(32'h8000_8000, 32'h8000_FFFF, 32'hFFFF_0000, 32'h7FFF_7FFF,
			32'h7FFF_8000, 2'd2);
		send_sample(16'hFFFF, 19'd0);
		send_sample(16'd0, 19'h7FFFF);
		drain();
	endtask

	function automatic bit [15:0] pick_temperature;
		return 16'(($urandom_range(1)) ? $urandom_range(65535) : $urandom_range(20000, 36000));
	endfunction

	// Random samples across every idle and stall mode, typical and raw calibration
	task automatic test_random;
		int unsigned modes[4][2] = '{'{0, 0}, '{50, 0}, '{0, 50}, '{8, 8}};
		bit [1:0] oss;
		for (int m = 0; m < 4; m++) begin
			idle_pct = modes[m][0];
			stall_pct = modes[m][1];
			oss = 2'($urandom_range(3));
			load_typical(oss);
			for (int i = 0; i < 200; i++) begin
				// sender holds off once until the pipeline is empty
				if (m == 0 && i == 100)
					drain();
				send_sample(pick_temperature(), 19'($urandom_range(20000, 65535) << oss));
				if ($urandom_range(19) == 0)
					send_sample(16'($urandom_range(65535)), 19'($urandom_range(524287)));
			end
			drain();
			load_calibration($urandom, $urandom, $urandom, $urandom, $urandom,
				2'($urandom_range(3)));
			for (int i = 0; i < 90; i++)
				send_sample(16'($urandom_range(65535)), 19'($urandom_range(524287)));
			drain();
		end
		idle_pct = 0;
		stall_pct = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cycles = 0;
		errors = 0;
		idle_pct = 0;
		stall_pct = 0;
		cal_ac12 = '0;
		cal_ac34 = '0;
		cal_ac56 = '0;
		cal_b12 = '0;
		cal_mcmd = '0;
		cal_oss = '0;
		ref_sum = '0;
		ref_taken = 0;
		ref_value = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_datasheet();
		test_faults_and_extremes();
		test_random();
		drain();

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire
